@@ sv/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register map and reset values for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int unsigned OPERAND_BITS_DEF = 31;
    localparam int unsigned FIELD_W          = 31;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_MODULUS = 1'b0;
    localparam logic [FIELD_W-1:0]   MODULUS_RESET   = FIELD_W'(1);

endpackage

@@ sv/modexp_if.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the operand beats and the result beats.
// ----------------------------------------------------------------------------
interface modexp_in_if import modexp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface modexp_out_if import modexp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result_value;
    logic               modulus_error;

    modport source (output valid, output result_value, output modulus_error, input ready);
    modport sink   (input valid, input result_value, input modulus_error, output ready);
endinterface

@@ sv/modexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes a * b mod m by interleaved shift, add and reduce, one multiplier
// bit per cycle from the most significant bit. Requires a <= m and m > 0.
// ----------------------------------------------------------------------------
module modexp_mulmod import modexp_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OPERAND_BITS-1:0] i_a,
    input  logic [OPERAND_BITS-1:0] i_b,
    input  logic [OPERAND_BITS-1:0] i_m,
    output logic                    o_done,
    output logic [OPERAND_BITS-1:0] o_result
);

    localparam int unsigned CNT_W = $clog2(OPERAND_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(OPERAND_BITS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [OPERAND_BITS-1:0] r_a;
    logic [OPERAND_BITS-1:0] r_b;
    logic [OPERAND_BITS-1:0] r_m;
    logic [OPERAND_BITS-1:0] r_r;

    logic [OPERAND_BITS+1:0] sum;
    logic [OPERAND_BITS+1:0] red1;
    logic [OPERAND_BITS+1:0] red2;
    logic [OPERAND_BITS+1:0] m_ext;

    always_comb begin
        m_ext = {2'b00, r_m};
        sum   = {1'b0, r_r, 1'b0} + (r_b[OPERAND_BITS-1] ? {2'b00, r_a} : '0);
        red1  = (sum >= m_ext) ? (sum - m_ext) : sum;
        red2  = (red1 >= m_ext) ? (red1 - m_ext) : red1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_r   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_r   <= red2[OPERAND_BITS-1:0];
            r_b   <= {r_b[OPERAND_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

@@ sv/modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Raises each base to its exponent modulo a configured modulus.
// ----------------------------------------------------------------------------
// An operand beat on i_in carries base_value and exponent_value; the block
// answers with one result beat on o_out carrying base^exponent mod modulus
// and a modulus_error flag. The modulus sits in the APB register at byte
// address 0 and resets to 1. A zero modulus gives result 0 with the flag set.
// One item is worked at a time by a single modular multiplier that handles
// one multiplier bit per cycle. An item costs one base reduction plus, for
// every exponent bit up to the highest set one, a squaring, a pass through
// the sequencing state and, for set bits, one more product. i_in.ready is
// high only while no item is in work. The result sits in an output
// register; the next operand beat is taken while it waits, and a finished
// result waits until the register is free. Reset empties the output
// register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_top import modexp_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    modexp_in_if.sink             i_in,
    modexp_out_if.source          o_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_STEP = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam logic [OPERAND_BITS-1:0] OP_ONE = OPERAND_BITS'(1);

    t_state                  r_state;
    t_state                  n_state;
    logic [FIELD_W-1:0]      r_modulus;
    logic [OPERAND_BITS-1:0] r_acc;
    logic [OPERAND_BITS-1:0] r_sq;
    logic [OPERAND_BITS-1:0] r_expo;
    logic                    r_err;
    logic                    r_out_valid;
    logic [FIELD_W-1:0]      r_out_result;
    logic                    r_out_err;

    logic                    cfg_wr;
    logic                    cfg_sel;
    logic                    in_fire;
    logic                    out_free;
    logic [OPERAND_BITS-1:0] mod_op;
    logic [OPERAND_BITS-1:0] base_op;
    logic [OPERAND_BITS-1:0] expo_op;
    logic                    mm_start;
    logic [OPERAND_BITS-1:0] mm_a;
    logic [OPERAND_BITS-1:0] mm_b;
    logic                    mm_done;
    logic [OPERAND_BITS-1:0] mm_result;

    assign cfg_sel  = (i_paddr[APB_ADDR_W-1:2] == CFG_REG_MODULUS);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && cfg_sel;
    assign o_pready = 1'b1;
    assign o_prdata = cfg_sel ? APB_DATA_W'(r_modulus) : '0;

    assign mod_op  = OPERAND_BITS'(r_modulus);
    assign base_op = OPERAND_BITS'(i_in.base_value);
    assign expo_op = OPERAND_BITS'(i_in.exponent_value);

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        mm_start = 1'b0;
        mm_a     = r_sq;
        mm_b     = r_sq;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (mod_op == '0) begin
                        n_state = S_DONE;
                    end else begin
                        mm_start = 1'b1;
                        mm_a     = OP_ONE;
                        mm_b     = base_op;
                        n_state  = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_expo == '0) begin
                    n_state = S_DONE;
                end else if (r_expo[0]) begin
                    mm_start = 1'b1;
                    mm_a     = r_acc;
                    n_state  = S_MUL;
                end else begin
                    mm_start = 1'b1;
                    n_state  = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    mm_start = 1'b1;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_modulus <= i_pwdata[FIELD_W-1:0];
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_acc  <= (mod_op == OP_ONE) ? '0 : OP_ONE;
            r_expo <= expo_op;
            r_err  <= (mod_op == '0);
        end
        if ((r_state == S_RED) && mm_done) begin
            r_sq <= mm_result;
        end
        if ((r_state == S_MUL) && mm_done) begin
            r_acc <= mm_result;
        end
        if ((r_state == S_SQR) && mm_done) begin
            r_sq   <= mm_result;
            r_expo <= r_expo >> 1;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_result <= r_err ? '0 : FIELD_W'(r_acc);
            r_out_err    <= r_err;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_value  = r_out_result;
    assign o_out.modulus_error = r_out_err;

    modexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (mod_op),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

endmodule

@@ sv/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions for the modular exponentiation top level.
// ----------------------------------------------------------------------------
module modexp_checker import modexp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] i_out_result,
    input logic               i_out_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result)
            && $stable(i_out_error))
        else $error("Result beat changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Operand beat taken while an item is in work.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> (i_out_result == '0))
        else $error("Modulus error with a nonzero result.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result beat shown right after reset.");

endmodule

bind modular_exponentiation_top modexp_checker u_modexp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result_value),
    .i_out_error  (o_out.modulus_error)
);

@@ sim/tb_modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives operand beats through the block and compares every result beat with
// a square and multiply prediction made at double width. The modulus register
// is programmed over APB between phases, including zero, one and the largest
// value, and read back. Operand beats come in bursts with random gaps, and the
// result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top import modexp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic               modulus_error;
    } t_modexp_result;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_UNUSED = 1'b1;
    localparam logic [FIELD_W-1:0]   MOD_MAX        = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    modexp_in_if  in_if ();
    modexp_out_if out_if ();

    t_modexp_result     pending_results[$];
    logic [FIELD_W-1:0] modulus_model   = MODULUS_RESET;
    int unsigned        mismatches      = 0;
    int unsigned        burst_left      = 0;
    logic               operands_driven = 1'b0;

    modular_exponentiation_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic t_modexp_result predict_modexp(input logic [FIELD_W-1:0] base_in,
                                                      input logic [FIELD_W-1:0] expo_in);
        logic [63:0]    m;
        logic [63:0]    acc;
        logic [63:0]    sq;
        t_modexp_result r;
        m = 64'(modulus_model);
        if (m == 64'd0) begin
            r.value         = '0;
            r.modulus_error = 1'b1;
            return r;
        end
        acc = 64'd1 % m;
        sq  = 64'(base_in) % m;
        for (int i = 0; i < OPERAND_BITS_DEF; i++) begin
            if (expo_in[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        r.value         = acc[FIELD_W-1:0];
        r.modulus_error = 1'b0;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %0d at %0t: %s expected %0h got %0h",
                     mismatches, $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_modexp_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending", '0,
                              32'(out_if.result_value));
            end else begin
                want = pending_results.pop_front();
                if (out_if.result_value !== want.value) begin
                    note_mismatch("result_value", 32'(want.value),
                                  32'(out_if.result_value));
                end
                if (out_if.modulus_error !== want.modulus_error) begin
                    note_mismatch("modulus_error", 32'(want.modulus_error),
                                  32'(out_if.modulus_error));
                end
            end
        end
    end

    initial begin : result_stalls
        int unsigned stall_cycles;
        int unsigned ready_cycles;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            ready_cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(2000, 6000)
                                                       : $urandom_range(1, 40);
            if (stall_cycles != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall_cycles) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat (ready_cycles) @(posedge i_clk);
        end
    end

    task automatic send_operands(input logic [FIELD_W-1:0] base_in,
                                 input logic [FIELD_W-1:0] expo_in);
        in_if.valid          <= 1'b1;
        in_if.base_value     <= base_in;
        in_if.exponent_value <= expo_in;
        operands_driven = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results = {pending_results, predict_modexp(base_in, expo_in)};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_if.valid <= 1'b0;
            operands_driven = 1'b0;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2500)
                                                : $urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(0, 7);
        end
    endtask

    task automatic wait_all_results();
        if (operands_driven) begin
            in_if.valid <= 1'b0;
            operands_driven = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == CFG_REG_MODULUS) begin
            modulus_model = data[FIELD_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            note_mismatch("modulus readback", want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_modulus(input logic [APB_DATA_W-1:0] value);
        wait_all_results();
        cfg_write(CFG_REG_MODULUS, value);
    endtask

    task automatic test_reset_modulus();
        cfg_read_check(CFG_REG_MODULUS, APB_DATA_W'(MODULUS_RESET));
        send_operands(31'd5, 31'd0);
        send_operands(MOD_MAX, MOD_MAX);
        wait_all_results();
    endtask

    task automatic test_register_access();
        cfg_write(CFG_REG_UNUSED, 32'd12345);
        cfg_read_check(CFG_REG_MODULUS, APB_DATA_W'(MODULUS_RESET));
        cfg_write(CFG_REG_MODULUS, 32'hFFFF_FFFF);
        cfg_read_check(CFG_REG_MODULUS, 32'h7FFF_FFFF);
        cfg_write(CFG_REG_MODULUS, 32'h8000_0000);
        cfg_read_check(CFG_REG_MODULUS, 32'h0000_0000);
    endtask

    task automatic test_directed();
        set_modulus(APB_DATA_W'(MOD_MAX));
        send_operands(31'd0, 31'd0);
        send_operands(31'd0, 31'd5);
        send_operands(MOD_MAX, 31'd1);
        send_operands(MOD_MAX - 31'd1, 31'd2);
        send_operands(31'd2, 31'd30);
        send_operands(31'd2, 31'd31);
        send_operands(31'd3, MOD_MAX);
        send_operands(MOD_MAX, MOD_MAX);
        send_operands(31'd1, MOD_MAX);
        send_operands(31'd12345, 31'd0);
        set_modulus(32'd1000);
        send_operands(31'd2, 31'd10);
        send_operands(31'd1999, 31'd3);
        send_operands(31'd7, 31'd1);
        set_modulus(32'd2);
        send_operands(31'd3, MOD_MAX);
        send_operands(31'd4, 31'd1);
        set_modulus(32'd1);
        send_operands(31'd5, 31'd0);
        send_operands(MOD_MAX, 31'd9);
        set_modulus(32'd0);
        send_operands(31'd5, 31'd3);
        send_operands(31'd0, 31'd0);
        send_operands(MOD_MAX, MOD_MAX);
        wait_all_results();
    endtask

    task automatic run_phase(input logic [APB_DATA_W-1:0] mod_value, input int unsigned count);
        logic [FIELD_W-1:0] base_in;
        logic [FIELD_W-1:0] expo_in;
        set_modulus(mod_value);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: base_in = FIELD_W'($urandom_range(0, 15));
                1: base_in = modulus_model - FIELD_W'(1) + FIELD_W'($urandom_range(0, 3));
                default: base_in = FIELD_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: expo_in = FIELD_W'($urandom_range(0, 64));
                1: expo_in = FIELD_W'($urandom) >> $urandom_range(0, 30);
                2: expo_in = FIELD_W'(1) << $urandom_range(0, 30);
                default: expo_in = FIELD_W'($urandom);
            endcase
            send_operands(base_in, expo_in);
        end
    endtask

    task automatic test_random();
        run_phase(APB_DATA_W'($urandom), 60);
        run_phase(APB_DATA_W'($urandom_range(2, 64)), 40);
        run_phase(APB_DATA_W'(MOD_MAX), 40);
        run_phase(32'd0, 15);
        run_phase(32'd1, 15);
        run_phase(APB_DATA_W'($urandom_range(1 << 16, 1 << 20)), 50);
        run_phase(APB_DATA_W'($urandom) | 32'h4000_0000, 50);
        wait_all_results();
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_if.valid          <= 1'b0;
        in_if.base_value     <= '0;
        in_if.exponent_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_register_access();
        test_directed();
        test_random();
        wait_all_results();
        repeat (2200) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
